/* sv/tcp_pkg.sv */
// Package for the tangent circle placement block.
// Holds datapath widths, pipeline depths, status codes and the stage structs.
// No dependencies.
package tcp_pkg;

  localparam int CW    = 32;          // coordinate width
  localparam int RW    = 31;          // radius width
  localparam int MAGW  = 32;          // magnitude of a centre delta or a radius sum
  localparam int SPW   = 33;          // radius span width
  localparam int D2W   = 65;          // squared centre distance
  localparam int SQW   = 64;          // squared radius sum
  localparam int NW    = 66;          // magnitude of the law-of-cosines numerator
  localparam int MW    = 66;          // multiplier operand width
  localparam int MHW   = MW / 2;      // multiplier partial product operand width
  localparam int PW    = 2 * MW;      // multiplier product width
  localparam int RADW  = 131;         // sqrt radicand width
  localparam int KW    = 66;          // sqrt result width, one pipeline stage per bit
  localparam int TW    = 100;         // signed numerator term width
  localparam int NUMW  = 100;         // divider numerator width
  localparam int DENW  = D2W + 1;     // divider denominator width
  localparam int QW    = 33;          // quotient bits below the clamp bit
  localparam int DIV_LAT = QW + 1;    // divider register stages
  localparam int VW    = CW + 3;      // width of the unsaturated coordinate

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_GAP   = 2'd1,
    ST_DEGEN = 2'd2
  } fit_status_t;

  typedef struct packed {
    logic [CW-1:0]   x1;
    logic [CW-1:0]   y1;
    logic [MAGW-1:0] dxm;
    logic [MAGW-1:0] dym;
    logic            dxn;
    logic            dyn;
  } front_t;

  typedef struct packed {
    front_t         fr;
    logic [NW-1:0]  nm;
    logic           nneg;
    logic [D2W-1:0] d2;
    logic           gap;
    logic           zero;
    logic           bad;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
    logic          sx;
    logic          sy;
    fit_status_t   status;
    logic          zap;
  } tail_t;

endpackage

/* sv/tcp_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on tcp_pkg for the operand width.
module tcp_mul import tcp_pkg::*; (
  input  logic          clk,
  input  logic [MW-1:0] a,
  input  logic [MW-1:0] b,
  output logic [PW-1:0] p
);

  logic [MW-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    pp_ll_r <= a[MHW-1:0] * b[MHW-1:0];
    pp_lh_r <= a[MHW-1:0] * b[MW-1:MHW];
    pp_hl_r <= a[MW-1:MHW] * b[MHW-1:0];
    pp_hh_r <= a[MW-1:MHW] * b[MW-1:MHW];
  end

  always_ff @(posedge clk) begin
    p_r <= {{MW{1'b0}}, pp_ll_r}
         + ({{(MW-1){1'b0}}, {1'b0, pp_lh_r} + {1'b0, pp_hl_r}} << MHW)
         + ({pp_hh_r, {MW{1'b0}}});
  end

  assign p = p_r;

endmodule

/* sv/tcp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a clamp flag
// for quotients at or above the top bit. Depends on tcp_pkg for widths.
module tcp_div import tcp_pkg::*; (
  input  logic            clk,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   q,
  output logic            sat
);

  logic [NUMW-1:0] rem_r [0:QW];
  logic [DENW-1:0] den_r [0:QW];
  logic [QW-1:0]   q_r   [0:QW];
  logic            sat_r [0:QW];

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    den_r[0] <= den;
    q_r[0]   <= '0;
    sat_r[0] <= ({1'b0, num} >= ({{(NUMW+1-DENW){1'b0}}, den} << QW));
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int I = QW - s;
    logic [NUMW-1:0] dsh;
    logic            ge;
    always_comb begin
      dsh = {{(NUMW-DENW){1'b0}}, den_r[s-1]} << I;
      ge  = rem_r[s-1] >= dsh;
    end
    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? rem_r[s-1] - dsh : rem_r[s-1];
      den_r[s] <= den_r[s-1];
      q_r[s]   <= q_r[s-1] | ({{(QW-1){1'b0}}, ge} << I);
      sat_r[s] <= sat_r[s-1];
    end
  end

  assign q   = q_r[QW];
  assign sat = sat_r[QW];

endmodule

/* sv/tangent_circle_placement.sv */
// Tangent circle placement: centre of a new circle touching two given circles.
// Fully pipelined: one transaction per clock, busy is always low.
// Most of the pipeline depth lies in the square root and the 34-stage
// dividers.
// Synchronous active-low reset clears the valid bits; the receiver cannot stall.
// Depends on tcp_pkg, tcp_mul and tcp_div.
module tangent_circle_placement import tcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_first_centre_x,
  input  logic signed [CW-1:0] in_first_centre_y,
  input  logic [RW-1:0]        in_first_radius,
  input  logic signed [CW-1:0] in_second_centre_x,
  input  logic signed [CW-1:0] in_second_centre_y,
  input  logic [RW-1:0]        in_second_radius,
  input  logic [RW-1:0]        in_new_radius,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_new_centre_x,
  output logic signed [CW-1:0] out_new_centre_y,
  output logic [1:0]           out_fit_status
);

  assign busy = 1'b0;

  // Input capture.
  logic          va_r;
  logic [CW-1:0] x1a_r, y1a_r, x2a_r, y2a_r;
  logic [RW-1:0] r1a_r, r2a_r, ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    x1a_r <= in_first_centre_x;
    y1a_r <= in_first_centre_y;
    r1a_r <= in_first_radius;
    x2a_r <= in_second_centre_x;
    y2a_r <= in_second_centre_y;
    r2a_r <= in_second_radius;
    ra_r  <= in_new_radius;
  end

  // Deltas and radius sums.
  logic [CW:0]     dx_s, dy_s, dx_ng, dy_ng;
  logic [MAGW-1:0] a1_nxt, a2_nxt;
  logic [SPW-1:0]  sp_nxt;
  logic            vb_r;
  front_t          fb_r;
  logic [MAGW-1:0] a1b_r, a2b_r;
  logic [SPW-1:0]  spb_r;

  always_comb begin
    dx_s   = {x2a_r[CW-1], x2a_r} - {x1a_r[CW-1], x1a_r};
    dy_s   = {y2a_r[CW-1], y2a_r} - {y1a_r[CW-1], y1a_r};
    dx_ng  = -dx_s;
    dy_ng  = -dy_s;
    a1_nxt = {1'b0, ra_r} + {1'b0, r1a_r};
    a2_nxt = {1'b0, ra_r} + {1'b0, r2a_r};
    sp_nxt = {2'b0, r1a_r} + {2'b0, r2a_r} + {1'b0, ra_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    fb_r.x1  <= x1a_r;
    fb_r.y1  <= y1a_r;
    fb_r.dxn <= dx_s[CW];
    fb_r.dyn <= dy_s[CW];
    fb_r.dxm <= dx_s[CW] ? dx_ng[MAGW-1:0] : dx_s[MAGW-1:0];
    fb_r.dym <= dy_s[CW] ? dy_ng[MAGW-1:0] : dy_s[MAGW-1:0];
    a1b_r    <= a1_nxt;
    a2b_r    <= a2_nxt;
    spb_r    <= sp_nxt;
  end

  // Squares.
  logic [PW-1:0] sq_dx, sq_dy, sq_a1, sq_a2, sq_sp;

  tcp_mul u_mul_dx (.clk(clk), .a({{(MW-MAGW){1'b0}}, fb_r.dxm}),
                    .b({{(MW-MAGW){1'b0}}, fb_r.dxm}), .p(sq_dx));
  tcp_mul u_mul_dy (.clk(clk), .a({{(MW-MAGW){1'b0}}, fb_r.dym}),
                    .b({{(MW-MAGW){1'b0}}, fb_r.dym}), .p(sq_dy));
  tcp_mul u_mul_a1 (.clk(clk), .a({{(MW-MAGW){1'b0}}, a1b_r}),
                    .b({{(MW-MAGW){1'b0}}, a1b_r}), .p(sq_a1));
  tcp_mul u_mul_a2 (.clk(clk), .a({{(MW-MAGW){1'b0}}, a2b_r}),
                    .b({{(MW-MAGW){1'b0}}, a2b_r}), .p(sq_a2));
  tcp_mul u_mul_sp (.clk(clk), .a({{(MW-SPW){1'b0}}, spb_r}),
                    .b({{(MW-SPW){1'b0}}, spb_r}), .p(sq_sp));

  logic   vc_r [0:1];
  front_t fc_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r[0] <= 1'b0;
      vc_r[1] <= 1'b0;
    end else begin
      vc_r[0] <= vb_r;
      vc_r[1] <= vc_r[0];
    end
  end

  always_ff @(posedge clk) begin
    fc_r[0] <= fb_r;
    fc_r[1] <= fc_r[0];
  end

  // Squared distance.
  logic           vd_r;
  front_t         fd_r;
  logic [D2W-1:0] d2d_r;
  logic [SQW-1:0] s1d_r, s2d_r;
  logic [NW-1:0]  ssqd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r[1];
    end
  end

  always_ff @(posedge clk) begin
    fd_r   <= fc_r[1];
    d2d_r  <= {1'b0, sq_dx[SQW-1:0]} + {1'b0, sq_dy[SQW-1:0]};
    s1d_r  <= sq_a1[SQW-1:0];
    s2d_r  <= sq_a2[SQW-1:0];
    ssqd_r <= sq_sp[NW-1:0];
  end

  // Range checks and d2 + R1^2.
  logic           ve_r;
  front_t         fe_r;
  logic [D2W-1:0] d2e_r;
  logic [SQW-1:0] s1e_r, s2e_r;
  logic [NW-1:0]  pe_r;
  logic           gape_r, zeroe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    fe_r    <= fd_r;
    d2e_r   <= d2d_r;
    s1e_r   <= s1d_r;
    s2e_r   <= s2d_r;
    pe_r    <= {1'b0, d2d_r} + {2'b0, s1d_r};
    gape_r  <= {1'b0, d2d_r} > ssqd_r;
    zeroe_r <= d2d_r == '0;
  end

  // Numerator N = d2 + R1^2 - R2^2 as sign and magnitude.
  logic          n_neg;
  logic [NW-1:0] n_pos, n_ngv;
  logic          vf_r;
  side_t         sf_r;
  logic [SQW-1:0] s1f_r;

  always_comb begin
    n_pos = pe_r - {2'b0, s2e_r};
    n_ngv = {2'b0, s2e_r} - pe_r;
    n_neg = pe_r < {2'b0, s2e_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    sf_r.fr   <= fe_r;
    sf_r.nm   <= n_neg ? n_ngv : n_pos;
    sf_r.nneg <= n_neg;
    sf_r.d2   <= d2e_r;
    sf_r.gap  <= gape_r;
    sf_r.zero <= zeroe_r;
    sf_r.bad  <= 1'b0;
    s1f_r     <= s1e_r;
  end

  // d2 * R1^2 and N^2.
  logic [PW-1:0] pr_ds, pr_nn;

  tcp_mul u_mul_ds (.clk(clk), .a({{(MW-D2W){1'b0}}, sf_r.d2}),
                    .b({{(MW-SQW){1'b0}}, s1f_r}), .p(pr_ds));
  tcp_mul u_mul_nn (.clk(clk), .a(sf_r.nm), .b(sf_r.nm), .p(pr_nn));

  logic  vg_r [0:1];
  side_t sg_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r[0] <= 1'b0;
      vg_r[1] <= 1'b0;
    end else begin
      vg_r[0] <= vf_r;
      vg_r[1] <= vg_r[0];
    end
  end

  always_ff @(posedge clk) begin
    sg_r[0] <= sf_r;
    sg_r[1] <= sg_r[0];
  end

  // Discriminant, then the square root pipeline, one result bit per stage.
  logic [PW:0]     disc_diff;
  logic            disc_bad;
  side_t           sq_in;
  logic            sqv_r    [0:KW];
  logic [RADW-1:0] sqrem_r  [0:KW];
  logic [KW-1:0]   sqroot_r [0:KW];
  side_t           sqs_r    [0:KW];

  always_comb begin
    disc_diff = {2'b0, pr_ds[PW-4:0], 2'b00} - {1'b0, pr_nn};
    disc_bad  = disc_diff[PW];
    sq_in     = sg_r[1];
    sq_in.bad = disc_bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r[0] <= 1'b0;
    end else begin
      sqv_r[0] <= vg_r[1];
    end
  end

  always_ff @(posedge clk) begin
    sqrem_r[0]  <= disc_bad ? '0 : disc_diff[RADW-1:0];
    sqroot_r[0] <= '0;
    sqs_r[0]    <= sq_in;
  end

  for (genvar k = 1; k <= KW; k++) begin : g_sqrt
    localparam int I = KW - k;
    logic [PW+1:0] trial, remx;
    logic          ge;
    always_comb begin
      trial = ({{(PW+2-KW){1'b0}}, sqroot_r[k-1]} << (I + 1))
            | ({{(PW+1){1'b0}}, 1'b1} << (2 * I));
      remx  = {{(PW+2-RADW){1'b0}}, sqrem_r[k-1]};
      ge    = remx >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k] <= 1'b0;
      end else begin
        sqv_r[k] <= sqv_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      sqrem_r[k]  <= ge ? (remx[RADW-1:0] - trial[RADW-1:0]) : sqrem_r[k-1];
      sqroot_r[k] <= sqroot_r[k-1] | ({{(KW-1){1'b0}}, ge} << I);
      sqs_r[k]    <= sqs_r[k-1];
    end
  end

  // Products N*dx, K*dy, N*dy, K*dx.
  side_t         sk;
  logic [KW-1:0] kk;
  logic [PW-1:0] pr_ndx, pr_kdy, pr_ndy, pr_kdx;

  assign sk = sqs_r[KW];
  assign kk = sqroot_r[KW];

  tcp_mul u_mul_ndx (.clk(clk), .a(sk.nm), .b({{(MW-MAGW){1'b0}}, sk.fr.dxm}), .p(pr_ndx));
  tcp_mul u_mul_kdy (.clk(clk), .a(kk),    .b({{(MW-MAGW){1'b0}}, sk.fr.dym}), .p(pr_kdy));
  tcp_mul u_mul_ndy (.clk(clk), .a(sk.nm), .b({{(MW-MAGW){1'b0}}, sk.fr.dym}), .p(pr_ndy));
  tcp_mul u_mul_kdx (.clk(clk), .a(kk),    .b({{(MW-MAGW){1'b0}}, sk.fr.dxm}), .p(pr_kdx));

  logic  vj_r [0:1];
  side_t sj_r [0:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vj_r[0] <= 1'b0;
      vj_r[1] <= 1'b0;
    end else begin
      vj_r[0] <= sqv_r[KW];
      vj_r[1] <= vj_r[0];
    end
  end

  always_ff @(posedge clk) begin
    sj_r[0] <= sk;
    sj_r[1] <= sj_r[0];
  end

  // Signed terms.
  logic [TW-1:0] u_ndx, u_kdy, u_ndy, u_kdx;
  logic          vt_r;
  side_t         st_r;
  logic [TW-1:0] t_ndx_r, t_kdy_r, t_ndy_r, t_kdx_r;

  always_comb begin
    u_ndx = {2'b0, pr_ndx[TW-3:0]};
    u_kdy = {2'b0, pr_kdy[TW-3:0]};
    u_ndy = {2'b0, pr_ndy[TW-3:0]};
    u_kdx = {2'b0, pr_kdx[TW-3:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else begin
      vt_r <= vj_r[1];
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= sj_r[1];
    t_ndx_r <= (sj_r[1].nneg ^ sj_r[1].fr.dxn) ? -u_ndx : u_ndx;
    t_kdy_r <= sj_r[1].fr.dyn ? u_kdy : -u_kdy;
    t_ndy_r <= (sj_r[1].nneg ^ sj_r[1].fr.dyn) ? -u_ndy : u_ndy;
    t_kdx_r <= sj_r[1].fr.dxn ? -u_kdx : u_kdx;
  end

  // Sums.
  logic          vu_r;
  side_t         su_r;
  logic [TW-1:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vu_r <= 1'b0;
    end else begin
      vu_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    su_r <= st_r;
    nx_r <= t_ndx_r + t_kdy_r;
    ny_r <= t_ndy_r + t_kdx_r;
  end

  // Magnitudes and signs.
  logic [TW-1:0] nx_ng, ny_ng;
  logic          vw_r;
  side_t         sw_r;
  logic [TW-1:0] mx_r, my_r;
  logic          sxw_r, syw_r;

  always_comb begin
    nx_ng = -nx_r;
    ny_ng = -ny_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r <= 1'b0;
    end else begin
      vw_r <= vu_r;
    end
  end

  always_ff @(posedge clk) begin
    sw_r  <= su_r;
    mx_r  <= nx_r[TW-1] ? nx_ng : nx_r;
    my_r  <= ny_r[TW-1] ? ny_ng : ny_r;
    sxw_r <= nx_r[TW-1];
    syw_r <= ny_r[TW-1];
  end

  // Rounding offset and divider operands.
  logic            vz_r;
  tail_t           tz_r;
  logic [NUMW-1:0] numx_r, numy_r;
  logic [DENW-1:0] den_r;
  fit_status_t     st_nxt;

  always_comb begin
    if (sw_r.gap) begin
      st_nxt = ST_GAP;
    end else if (sw_r.zero || sw_r.bad) begin
      st_nxt = ST_DEGEN;
    end else begin
      st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vz_r <= 1'b0;
    end else begin
      vz_r <= vw_r;
    end
  end

  always_ff @(posedge clk) begin
    tz_r.x1     <= sw_r.fr.x1;
    tz_r.y1     <= sw_r.fr.y1;
    tz_r.sx     <= sxw_r;
    tz_r.sy     <= syw_r;
    tz_r.status <= st_nxt;
    tz_r.zap    <= sw_r.gap | sw_r.zero;
    numx_r      <= mx_r + {{(NUMW-D2W){1'b0}}, sw_r.d2};
    numy_r      <= my_r + {{(NUMW-D2W){1'b0}}, sw_r.d2};
    den_r       <= {sw_r.d2, 1'b0};
  end

  // Division by 2*d2.
  logic [QW-1:0] qx, qy;
  logic          satx, saty;

  tcp_div u_div_x (.clk(clk), .num(numx_r), .den(den_r), .q(qx), .sat(satx));
  tcp_div u_div_y (.clk(clk), .num(numy_r), .den(den_r), .q(qy), .sat(saty));

  logic  vdl_r [0:DIV_LAT-1];
  tail_t tdl_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdl_r[0] <= 1'b0;
    end else begin
      vdl_r[0] <= vz_r;
    end
  end

  always_ff @(posedge clk) begin
    tdl_r[0] <= tz_r;
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vdl_r[j] <= 1'b0;
      end else begin
        vdl_r[j] <= vdl_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      tdl_r[j] <= tdl_r[j-1];
    end
  end

  // Offset from the first centre and saturation.
  tail_t         tf;
  logic [QW:0]   qmx, qmy;
  logic [VW-1:0] vx, vy;
  logic [CW-1:0] cx, cy;
  logic          out_valid_r;
  logic [CW-1:0] out_x_r, out_y_r;
  logic [1:0]    out_st_r;

  always_comb begin
    tf  = tdl_r[DIV_LAT-1];
    qmx = satx ? {1'b1, {QW{1'b0}}} : {1'b0, qx};
    qmy = saty ? {1'b1, {QW{1'b0}}} : {1'b0, qy};
    vx  = tf.sx ? {{3{tf.x1[CW-1]}}, tf.x1} - {1'b0, qmx}
                : {{3{tf.x1[CW-1]}}, tf.x1} + {1'b0, qmx};
    vy  = tf.sy ? {{3{tf.y1[CW-1]}}, tf.y1} - {1'b0, qmy}
                : {{3{tf.y1[CW-1]}}, tf.y1} + {1'b0, qmy};
    if (vx[VW-1:CW-1] == '0 || vx[VW-1:CW-1] == '1) begin
      cx = vx[CW-1:0];
    end else begin
      cx = vx[VW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    if (vy[VW-1:CW-1] == '0 || vy[VW-1:CW-1] == '1) begin
      cy = vy[CW-1:0];
    end else begin
      cy = vy[VW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vdl_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_x_r  <= tf.zap ? '0 : cx;
    out_y_r  <= tf.zap ? '0 : cy;
    out_st_r <= tf.status;
  end

  assign out_valid        = out_valid_r;
  assign out_new_centre_x = out_x_r;
  assign out_new_centre_y = out_y_r;
  assign out_fit_status   = out_st_r;

endmodule

/* sim/testbench.sv */
// Testbench for tangent_circle_placement: directed and random transactions,
// each result checked against an in-bench predictor of the tangent fit.
// Depends on tcp_pkg and the tangent_circle_placement RTL.
module testbench;
  import tcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [191:0] wide_t;
  typedef logic signed [191:0] swide_t;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    fit_status_t          status;
  } fit_t;

  localparam int LATENCY   = 117;
  localparam int MAX_CYCLE = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_first_centre_x = '0;
  logic signed [CW-1:0] in_first_centre_y = '0;
  logic [RW-1:0]        in_first_radius = '0;
  logic signed [CW-1:0] in_second_centre_x = '0;
  logic signed [CW-1:0] in_second_centre_y = '0;
  logic [RW-1:0]        in_second_radius = '0;
  logic [RW-1:0]        in_new_radius = '0;
  logic                 out_valid;
  logic signed [CW-1:0] out_new_centre_x;
  logic signed [CW-1:0] out_new_centre_y;
  logic [1:0]           out_fit_status;

  fit_t expected_fits[$];
  int   accepted_cnt = 0;
  int   cycle_cnt = 0;
  int   error_cnt = 0;

  tangent_circle_placement u_top (.*);

  always #5 clk = ~clk;

  function automatic wide_t isqrt(input wide_t v);
    wide_t r, c;
    r = '0;
    for (int b = 69; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] offset_centre(input longint base, input swide_t num,
                                                  input wide_t d2);
    logic neg;
    wide_t mag, q;
    longint qm, v;
    neg = num < 0;
    mag = neg ? wide_t'(-num) : wide_t'(num);
    q = (mag + d2) / (d2 + d2);
    qm = (q >= (wide_t'(1) << 33)) ? (longint'(1) << 33) : longint'(q[63:0]);
    v = neg ? base - qm : base + qm;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic fit_t fit_tangent(input logic signed [CW-1:0] x1, y1,
                                       input logic [RW-1:0] r1,
                                       input logic signed [CW-1:0] x2, y2,
                                       input logic [RW-1:0] r2, rn);
    fit_t f;
    longint dxl, dyl;
    wide_t dxm, dym, d2, span, s1, s2, disc, nmag, kk;
    swide_t nsig, nx, ny;
    dxl = longint'(x2) - longint'(x1);
    dyl = longint'(y2) - longint'(y1);
    dxm = wide_t'(dxl < 0 ? -dxl : dxl);
    dym = wide_t'(dyl < 0 ? -dyl : dyl);
    d2 = dxm * dxm + dym * dym;
    span = wide_t'(r1) + wide_t'(r2) + wide_t'(rn) + wide_t'(rn);
    s1 = (wide_t'(rn) + wide_t'(r1)) * (wide_t'(rn) + wide_t'(r1));
    s2 = (wide_t'(rn) + wide_t'(r2)) * (wide_t'(rn) + wide_t'(r2));
    f.cx = '0;
    f.cy = '0;
    f.status = ST_OK;
    if (d2 > span * span) begin
      f.status = ST_GAP;
      return f;
    end
    if (d2 == 0) begin
      f.status = ST_DEGEN;
      return f;
    end
    nsig = swide_t'(d2 + s1) - swide_t'(s2);
    nmag = nsig < 0 ? wide_t'(-nsig) : wide_t'(nsig);
    disc = 4 * d2 * s1;
    if (disc < nmag * nmag) begin
      f.status = ST_DEGEN;
      kk = '0;
    end else begin
      kk = isqrt(disc - nmag * nmag);
    end
    nx = nsig * swide_t'(dxl) - swide_t'(kk) * swide_t'(dyl);
    ny = nsig * swide_t'(dyl) + swide_t'(kk) * swide_t'(dxl);
    f.cx = offset_centre(longint'(x1), nx, d2);
    f.cy = offset_centre(longint'(y1), ny, d2);
    return f;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && start && !busy) begin
      expected_fits.insert(expected_fits.size(), fit_tangent(in_first_centre_x,
          in_first_centre_y, in_first_radius, in_second_centre_x, in_second_centre_y,
          in_second_radius, in_new_radius));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (rst_n && out_valid) begin
      if (expected_fits.size() == 0) begin
        $error("result with no transaction outstanding");
        error_cnt++;
      end else begin
        fit_t e;
        e = expected_fits.pop_front();
        if (out_new_centre_x !== e.cx) begin
          $error("new_centre_x expected %0d actual %0d", e.cx, out_new_centre_x);
          error_cnt++;
        end
        if (out_new_centre_y !== e.cy) begin
          $error("new_centre_y expected %0d actual %0d", e.cy, out_new_centre_y);
          error_cnt++;
        end
        if (out_fit_status !== e.status) begin
          $error("fit_status expected %0d actual %0d", e.status, out_fit_status);
          error_cnt++;
        end
      end
    end
  end

  task automatic send_pair(input logic signed [CW-1:0] x1, y1, input logic [RW-1:0] r1,
                           input logic signed [CW-1:0] x2, y2, input logic [RW-1:0] r2,
                           input logic [RW-1:0] rn);
    int prev;
    @(negedge clk);
    in_first_centre_x = x1;
    in_first_centre_y = y1;
    in_first_radius = r1;
    in_second_centre_x = x2;
    in_second_centre_y = y2;
    in_second_radius = r2;
    in_new_radius = rn;
    start = 1'b1;
    prev = accepted_cnt;
    do begin
      @(posedge clk);
      #1;
    end while (accepted_cnt == prev);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic test_touching();
    send_pair(0, 0, 31'h10000, 32'h20000, 0, 31'h10000, 31'h10000);
    send_pair(32'h50000, -32'sh30000, 31'h8000, -32'sh20000, 32'h40000, 31'h18000, 31'h4000);
    send_pair(0, 0, 0, 1, 0, 0, 1);
    send_pair(0, 0, 0, 1, 1, 0, 0);
    idle_cycles(3);
  endtask

  task automatic test_gap();
    send_pair(0, 0, 31'h10000, 32'h100000, 0, 31'h10000, 31'h10000);
    send_pair(32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    send_pair(0, 0, 0, 3, 0, 0, 1);
  endtask

  task automatic test_coincident();
    send_pair(32'h1234, 32'h5678, 31'h100, 32'h1234, 32'h5678, 31'h200, 31'h300);
    send_pair(0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_cosine_range();
    send_pair(0, 0, 31'h100000, 32'h100, 0, 31'h10, 31'h10);
    send_pair(0, 0, 31'h10, 32'h100, 0, 31'h100000, 31'h10);
  endtask

  task automatic test_extremes();
    send_pair(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 32'sh7ffffff0, 32'sh7ffffff0,
              31'h7fffffff, 31'h7fffffff);
    send_pair(32'sh80000000, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 32'sh80000000,
              31'h7fffffff, 31'h7fffffff);
    send_pair(32'sh7fffffff, 32'sh80000000, 31'h40000000, 32'sh80000000, 32'sh7fffffff,
              31'h40000000, 31'h7fffffff);
    send_pair(32'sh7fff0000, 0, 31'h1000000, 32'sh7fff8000, 0, 31'h1000000, 31'h7fffffff);
    send_pair(-32'sh7fff0000, 0, 31'h1000000, -32'sh7fff8000, 0, 31'h1000000, 31'h7fffffff);
  endtask

  task automatic test_random(input int count);
    int sent;
    int burst;
    logic signed [CW-1:0] x1, y1, x2, y2;
    logic [RW-1:0] r1, r2, rn;
    longint span, dx, dy;
    int sh;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 2) begin
          x1 = $urandom; y1 = $urandom; x2 = $urandom; y2 = $urandom;
          r1 = RW'($urandom); r2 = RW'($urandom); rn = RW'($urandom);
        end else begin
          sh = $urandom_range(4, 24);
          r1 = RW'($urandom >> (sh + 1 + $urandom_range(0, 4)));
          r2 = RW'($urandom >> (sh + 1 + $urandom_range(0, 4)));
          rn = RW'($urandom >> (sh + 1 + $urandom_range(0, 4)));
          x1 = $signed($urandom) >>> $urandom_range(1, 20);
          y1 = $signed($urandom) >>> $urandom_range(1, 20);
          span = longint'(r1) + r2 + 2 * longint'(rn) + 1;
          dx = longint'({$urandom, $urandom} % (2 * span)) - span;
          dy = longint'({$urandom, $urandom} % (2 * span)) - span;
          x2 = x1 + dx[31:0];
          y2 = y1 + dy[31:0];
        end
        send_pair(x1, y1, r1, x2, y2, r2, rn);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 8));
    end
    idle_cycles(0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_touching();
    test_gap();
    test_coincident();
    test_cosine_range();
    test_extremes();
    test_random(550);
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_cnt == 0 && expected_fits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
